// File: hdl/pffs_pkg.sv
// ----------------------------------------------------------------------------
// pffs_pkg: shared types and constants of the first-fit slot scheduler
// Sizes, outcome and mode codes, sort key width, run state type.
// ----------------------------------------------------------------------------
package pffs_pkg;

  localparam int unsigned MaxSlots = 16;
  localparam int unsigned MaxTasks = 32;
  localparam int unsigned SlotIdxW = $clog2(MaxSlots);
  localparam int unsigned SlotCntW = $clog2(MaxSlots + 1);
  localparam int unsigned TaskIdxW = $clog2(MaxTasks);
  localparam int unsigned TaskCntW = 6;
  localparam int unsigned KeyW = 48;
  localparam logic [10:0] NoDeadlineMinute = 11'd1440;

  typedef enum logic [1:0] {
    MODE_SLOT = 2'd0,
    MODE_TASK = 2'd1,
    MODE_RUN  = 2'd2,
    MODE_NONE = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    OC_PLACED  = 3'd0,
    OC_MISSING = 3'd1,
    OC_INVALID = 3'd2,
    OC_NO_SLOT = 3'd3,
    OC_SUMMARY = 3'd4
  } outcome_e;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_BAD,
    ST_SELECT,
    ST_FIT,
    ST_EMIT,
    ST_SUMMARY
  } run_state_e;

  // Request from the controller to the slot chain.
  typedef struct packed {
    logic        load;
    logic [10:0] start;
    logic [10:0] finish;
    logic        clear;
    logic        probe;
    logic        commit;
    logic [10:0] dur;
  } slot_cmd_t;

  // Slot that a request searches for, carried along the chain.
  typedef struct packed {
    logic        found;
    logic [10:0] start;
  } fit_t;

endpackage

// File: hdl/priority_first_fit_slot_scheduler_unit.sv
// ----------------------------------------------------------------------------
// priority_first_fit_slot_scheduler_unit: first-fit task placement
// Loads slots and tasks, then places tasks in key order into the slot chain.
// ----------------------------------------------------------------------------
// Usage: one input channel (valid/ready) carries load and run items, one
// output channel (valid/ready) carries result items.
// Slot and task items are taken one per cycle while the output register is
// free and give no result. A run item first reports tasks with a missing or
// invalid duration, one per cycle in arrival order while the receiver keeps
// up, scanning the task memory. Then each task with a valid duration costs one
// selection pass over the task memory and one fit step in the slot chain, where
// the first fit ripples combinationally through all slot cells. Input is not
// accepted during a run. A stalled receiver holds the result register and
// freezes the run at its next result. After the summary all slots and tasks
// clear.
// Reset empties both stores and returns the block to loading.
// ----------------------------------------------------------------------------
module priority_first_fit_slot_scheduler_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [10:0] slot_start_i,
  input  logic [10:0] slot_end_i,
  input  logic [15:0] task_id_i,
  input  logic        task_completed_i,
  input  logic [1:0]  duration_state_i,
  input  logic [10:0] duration_i,
  input  logic [1:0]  priority_req_i,
  input  logic        has_deadline_i,
  input  logic [15:0] deadline_day_i,
  input  logic        has_deadline_time_i,
  input  logic [10:0] deadline_minute_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] result_task_o,
  output logic [2:0]  outcome_o,
  output logic [10:0] placed_start_o,
  output logic [11:0] placed_end_o,
  output logic [15:0] placed_minutes_total_o,
  output logic [5:0]  total_tasks_o,
  output logic [5:0]  completed_count_o,
  output logic        last_o
);

  localparam int unsigned TW = pffs_pkg::TaskIdxW;
  localparam int unsigned CW = pffs_pkg::TaskCntW;

  // Task memory: id + duration state, and sort key. Read one entry a cycle unless a report waits on the receiver.
  logic [17:0]             ident_mem [pffs_pkg::MaxTasks];
  logic [pffs_pkg::KeyW-1:0] key_mem [pffs_pkg::MaxTasks];
  logic [pffs_pkg::MaxTasks-1:0] done_q, done_d;  // placed or reported without a slot

  pffs_pkg::run_state_e state_q, state_d;
  logic [CW-1:0]  task_cnt_q, task_cnt_d;
  logic [CW-1:0]  compl_q, compl_d;
  logic [pffs_pkg::SlotCntW-1:0] slot_cnt_q, slot_cnt_d;
  logic [CW-1:0]  scan_q, scan_d;       // address being read
  logic           rd_vld_q, rd_vld_d;   // read data belongs to rd_idx_q
  logic [TW-1:0]  rd_idx_q;
  logic [17:0]    rd_ident_q;
  logic [pffs_pkg::KeyW-1:0] rd_key_q;
  logic           best_vld_q, best_vld_d;
  logic [TW-1:0]  best_idx_q, best_idx_d;
  logic [pffs_pkg::KeyW-1:0] best_key_q, best_key_d;
  logic [15:0]    best_id_q, best_id_d;
  logic [15:0]    total_q, total_d;

  logic           out_vld_q, out_vld_d;
  logic [15:0]    o_task_q, o_task_d;
  logic [2:0]     o_oc_q, o_oc_d;
  logic [10:0]    o_ps_q, o_ps_d;
  logic [11:0]    o_pe_q, o_pe_d;
  logic [15:0]    o_tot_q, o_tot_d;
  logic [5:0]     o_nt_q, o_nt_d;
  logic [5:0]     o_nc_q, o_nc_d;
  logic           o_last_q, o_last_d;

  pffs_pkg::slot_cmd_t cmd;
  pffs_pkg::fit_t      fit;
  logic          accept;
  logic          out_free;
  logic          task_wr;
  logic          rd_en;
  logic [1:0]    rank;
  logic [15:0]   day;
  logic [10:0]   minute;
  logic [pffs_pkg::KeyW-1:0] new_key;
  logic [10:0]   best_dur;
  logic [1:0]    rd_ds;
  logic          rd_cand;

  assign out_free = !out_vld_q || out_ready_i;
  assign in_ready_o = (state_q == pffs_pkg::ST_LOAD) && out_free;
  assign accept = in_valid_i && in_ready_o;

  assign rank = (priority_req_i == 2'd3) ? 2'd2 : priority_req_i;
  assign day = has_deadline_i ? deadline_day_i : 16'd0;
  assign minute = !has_deadline_i ? 11'd0 :
                  (has_deadline_time_i ? deadline_minute_i : pffs_pkg::NoDeadlineMinute);
  assign new_key = {task_completed_i, !has_deadline_i, day, minute, rank,
                    11'h7FF - duration_i, task_cnt_q};
  assign task_wr = accept && (mode_i == pffs_pkg::MODE_TASK) &&
                   (task_cnt_q < CW'(pffs_pkg::MaxTasks));

  // Hold the read data while a report waits on the receiver.
  assign rd_en = !((state_q == pffs_pkg::ST_BAD) && !out_free);

  always_ff @(posedge clk_i) begin
    if (task_wr) begin
      ident_mem[task_cnt_q[TW-1:0]] <= {duration_state_i, task_id_i};
      key_mem[task_cnt_q[TW-1:0]] <= new_key;
    end
    if (rd_en) begin
      rd_ident_q <= ident_mem[scan_q[TW-1:0]];
      rd_key_q <= key_mem[scan_q[TW-1:0]];
      rd_idx_q <= scan_q[TW-1:0];
    end
  end

  assign rd_ds = rd_ident_q[17:16];
  assign rd_cand = rd_vld_q && !done_q[rd_idx_q] && !rd_key_q[47] && (rd_ds == 2'd0);
  assign best_dur = 11'h7FF - best_key_q[16:6];

  always_comb begin
    cmd = '0;
    cmd.load = accept && (mode_i == pffs_pkg::MODE_SLOT);
    cmd.start = slot_start_i;
    cmd.finish = slot_end_i;
    cmd.dur = best_dur;
    cmd.commit = (state_q == pffs_pkg::ST_FIT) && out_free;
    cmd.clear = (state_q == pffs_pkg::ST_SUMMARY) && out_free;
  end

  pffs_slot_chain u_chain (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd),
    .fit_o (fit)
  );

  always_comb begin
    state_d = state_q;
    task_cnt_d = task_cnt_q;
    compl_d = compl_q;
    slot_cnt_d = slot_cnt_q;
    scan_d = scan_q;
    rd_vld_d = 1'b0;
    best_vld_d = best_vld_q;
    best_idx_d = best_idx_q;
    best_key_d = best_key_q;
    best_id_d = best_id_q;
    total_d = total_q;
    done_d = done_q;
    out_vld_d = out_vld_q && !out_ready_i;
    o_task_d = o_task_q;
    o_oc_d = o_oc_q;
    o_ps_d = o_ps_q;
    o_pe_d = o_pe_q;
    o_tot_d = o_tot_q;
    o_nt_d = o_nt_q;
    o_nc_d = o_nc_q;
    o_last_d = o_last_q;
    case (state_q)
      pffs_pkg::ST_LOAD: begin
        if (task_wr) begin
          task_cnt_d = task_cnt_q + 1'b1;
          compl_d = compl_q + CW'(task_completed_i);
        end
        if (cmd.load && slot_cnt_q < pffs_pkg::SlotCntW'(pffs_pkg::MaxSlots)) begin
          slot_cnt_d = slot_cnt_q + 1'b1;
        end
        if (accept && mode_i == pffs_pkg::MODE_RUN) begin
          scan_d = '0;
          done_d = '0;
          total_d = '0;
          state_d = pffs_pkg::ST_BAD;
        end
      end
      pffs_pkg::ST_BAD: begin
        // walk tasks in arrival order; report bad durations
        if (out_free) begin
          if (rd_vld_q && !rd_key_q[47] && rd_ds != 2'd0) begin
            out_vld_d = 1'b1;
            o_task_d = rd_ident_q[15:0];
            o_oc_d = (rd_ds == 2'd1) ? pffs_pkg::OC_MISSING : pffs_pkg::OC_INVALID;
            o_ps_d = '0;
            o_pe_d = '0;
            o_tot_d = '0;
            o_nt_d = '0;
            o_nc_d = '0;
            o_last_d = 1'b0;
          end
          if (scan_q < task_cnt_q) begin
            rd_vld_d = 1'b1;
            scan_d = scan_q + 1'b1;
          end else begin
            scan_d = '0;
            best_vld_d = 1'b0;
            state_d = pffs_pkg::ST_SELECT;
          end
        end else begin
          rd_vld_d = rd_vld_q;
        end
      end
      pffs_pkg::ST_SELECT: begin
        // find smallest remaining key
        if (rd_cand && (!best_vld_q || rd_key_q < best_key_q)) begin
          best_vld_d = 1'b1;
          best_idx_d = rd_idx_q;
          best_key_d = rd_key_q;
          best_id_d = rd_ident_q[15:0];
        end
        if (scan_q < task_cnt_q) begin
          rd_vld_d = 1'b1;
          scan_d = scan_q + 1'b1;
        end else if (!rd_vld_q) begin
          state_d = best_vld_q ? pffs_pkg::ST_FIT : pffs_pkg::ST_SUMMARY;
        end
      end
      pffs_pkg::ST_FIT: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          o_task_d = best_id_q;
          o_tot_d = '0;
          o_nt_d = '0;
          o_nc_d = '0;
          o_last_d = 1'b0;
          if (fit.found) begin
            o_oc_d = pffs_pkg::OC_PLACED;
            o_ps_d = fit.start;
            o_pe_d = {1'b0, fit.start} + {1'b0, best_dur};
            total_d = total_q + 16'(best_dur);
          end else begin
            o_oc_d = pffs_pkg::OC_NO_SLOT;
            o_ps_d = '0;
            o_pe_d = '0;
          end
          done_d[best_idx_q] = 1'b1;
          best_vld_d = 1'b0;
          scan_d = '0;
          state_d = pffs_pkg::ST_SELECT;
        end
      end
      pffs_pkg::ST_SUMMARY: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          o_task_d = '0;
          o_oc_d = pffs_pkg::OC_SUMMARY;
          o_ps_d = '0;
          o_pe_d = '0;
          o_tot_d = total_q;
          o_nt_d = task_cnt_q;
          o_nc_d = compl_q;
          o_last_d = 1'b1;
          task_cnt_d = '0;
          compl_d = '0;
          slot_cnt_d = '0;
          state_d = pffs_pkg::ST_LOAD;
        end
      end
      default: state_d = pffs_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pffs_pkg::ST_LOAD;
      task_cnt_q <= '0;
      compl_q <= '0;
      slot_cnt_q <= '0;
      scan_q <= '0;
      rd_vld_q <= 1'b0;
      best_vld_q <= 1'b0;
      done_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      task_cnt_q <= task_cnt_d;
      compl_q <= compl_d;
      slot_cnt_q <= slot_cnt_d;
      scan_q <= scan_d;
      rd_vld_q <= rd_vld_d;
      best_vld_q <= best_vld_d;
      done_q <= done_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_idx_q <= best_idx_d;
    best_key_q <= best_key_d;
    best_id_q <= best_id_d;
    total_q <= total_d;
    o_task_q <= o_task_d;
    o_oc_q <= o_oc_d;
    o_ps_q <= o_ps_d;
    o_pe_q <= o_pe_d;
    o_tot_q <= o_tot_d;
    o_nt_q <= o_nt_d;
    o_nc_q <= o_nc_d;
    o_last_q <= o_last_d;
  end

  assign out_valid_o = out_vld_q;
  assign result_task_o = o_task_q;
  assign outcome_o = o_oc_q;
  assign placed_start_o = o_ps_q;
  assign placed_end_o = o_pe_q;
  assign placed_minutes_total_o = o_tot_q;
  assign total_tasks_o = o_nt_q;
  assign completed_count_o = o_nc_q;
  assign last_o = o_last_q;

`ifndef SYNTH
  a_no_accept_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != pffs_pkg::ST_LOAD) |-> !in_ready_o)
    else $error("input taken during a run");
  a_summary_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && o_last_q && !$stable(out_vld_q)) |-> (state_q == pffs_pkg::ST_LOAD))
    else $error("summary sent before run ended");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    compl_q <= task_cnt_q)
    else $error("completed count exceeds task count");
`endif

endmodule

// File: hdl/pffs_slot_cell.sv
// ----------------------------------------------------------------------------
// pffs_slot_cell: one free slot of the chain
// Holds one slot, takes a load when it is the first empty cell, claims a fit.
// ----------------------------------------------------------------------------
module pffs_slot_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pffs_pkg::slot_cmd_t cmd_i,
  input  logic                load_en_i,
  input  logic                used_prev_i,
  output logic                used_o,
  input  pffs_pkg::fit_t      fit_i,
  output pffs_pkg::fit_t      fit_o
);

  logic        used_q, used_d;
  logic        live_q, live_d;
  logic [10:0] begin_q, begin_d;
  logic [10:0] finish_q, finish_d;
  logic        fits;
  logic        claim;
  logic [10:0] new_begin;

  assign fits = live_q && (finish_q >= begin_q) && ((finish_q - begin_q) >= cmd_i.dur);
  assign claim = !fit_i.found && fits;
  assign new_begin = begin_q + cmd_i.dur;
  assign used_o = used_q;

  always_comb begin
    fit_o = fit_i;
    if (claim) begin
      fit_o.found = 1'b1;
      fit_o.start = begin_q;
    end
  end

  always_comb begin
    used_d = used_q;
    live_d = live_q;
    begin_d = begin_q;
    finish_d = finish_q;
    if (cmd_i.clear) begin
      used_d = 1'b0;
      live_d = 1'b0;
    end else if (cmd_i.load && load_en_i && used_prev_i && !used_q) begin
      used_d = 1'b1;
      live_d = 1'b1;
      begin_d = cmd_i.start;
      finish_d = cmd_i.finish;
    end else if (cmd_i.commit && claim) begin
      begin_d = new_begin;
      if (new_begin == finish_q) begin
        live_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
      live_q <= 1'b0;
    end else begin
      used_q <= used_d;
      live_q <= live_d;
    end
  end

  always_ff @(posedge clk_i) begin
    begin_q <= begin_d;
    finish_q <= finish_d;
  end

endmodule

// File: hdl/pffs_slot_chain.sv
// ----------------------------------------------------------------------------
// pffs_slot_chain: row of slot cells in load order
// First-fit search ripples from cell zero; the winner advances its start.
// ----------------------------------------------------------------------------
module pffs_slot_chain (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pffs_pkg::slot_cmd_t cmd_i,
  output pffs_pkg::fit_t      fit_o
);

  pffs_pkg::fit_t fit_w [pffs_pkg::MaxSlots+1];
  logic           used_w [pffs_pkg::MaxSlots+1];

  assign fit_w[0] = '0;
  assign used_w[0] = 1'b1;

  for (genvar g = 0; g < pffs_pkg::MaxSlots; g++) begin : g_cell
    pffs_slot_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd_i),
      .load_en_i  (1'b1),
      .used_prev_i(used_w[g]),
      .used_o     (used_w[g+1]),
      .fit_i      (fit_w[g]),
      .fit_o      (fit_w[g+1])
    );
  end

  assign fit_o = fit_w[pffs_pkg::MaxSlots];

endmodule
